>>> hdl/best_subset_score_search_unit_macros.svh
// Assertion helpers for the search unit
`ifndef BEST_SUBSET_SCORE_SEARCH_UNIT_MACROS_SVH
`define BEST_SUBSET_SCORE_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BSSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsss assertion failed");

// next-cycle implication, checked out of reset
`define BSSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsss assertion failed");

`endif

>>> hdl/bsss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsss_pkg;

    localparam int MAX_NODES  = 16;
    localparam int TABLE_ROWS = 1024;

    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int NODE_W     = 4;
    localparam int MASK_W     = 16;
    localparam int SCORE_W    = 32;
    localparam int NCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int MASK_BITS  = (MAX_NODES < MASK_W) ? MAX_NODES : MASK_W;

    localparam logic [CNT_W-1:0]          ROWS_TOTAL = CNT_W'(TABLE_ROWS);
    localparam logic [IDX_W-1:0]          LAST_ROW   = IDX_W'(TABLE_ROWS - 1);
    localparam logic signed [SCORE_W-1:0] SCORE_MIN  = {1'b1, {(SCORE_W-1){1'b0}}};

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST  = NCNT_W'(16);
    localparam logic [CNT_W-1:0]  ROWS_IN_USE_RST = CNT_W'(1024);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SUBSET = 2'd1,
        KIND_ROW    = 2'd2,
        KIND_IGNORE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT  = 1'd0,
        CFG_ROWS_IN_USE = 1'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OWN,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind                      kind;
        logic [IDX_W-1:0]           row_index;
        logic [NODE_W-1:0]          node;
        logic [MASK_W-1:0]          parent_mask;
        logic signed [SCORE_W-1:0]  entry_score;
        logic [IDX_W-1:0]           range_first;
        logic [IDX_W-1:0]           range_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SCORE_W-1:0]  best_score;
        logic [IDX_W-1:0]           best_index;
        logic                       found;
    } t_out_beat;

    typedef struct packed {
        logic [NODE_W-1:0]          node;
        logic [MASK_W-1:0]          mask;
        logic signed [SCORE_W-1:0]  score;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage
`default_nettype wire

>>> hdl/bsss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bsss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hdl/best_subset_score_search_unit.sv
// Best parent-subset score search over a 1024-row table held in one RAM.
// Input channel (i_in_valid / o_in_stall, beat i_in_data) carries loads and
// queries; output channel (o_out_valid / i_out_stall, beat o_out_data) carries
// one result per query, none per load. Config writes via i_cfg_we with
// i_cfg_index / i_cfg_data: 0 node_count, 1 rows_in_use.
// A load is written into the table at the accepting edge.
// A subset query reads one row per cycle through the RAM's single read port;
// its result is registered after the rows in range_first..range_last have
// been read; an empty range reads no rows.
// A row query first fetches its own row, then reads rows 0..L-1, one per
// cycle, L being rows_in_use capped at 1024; when L is 0, no rows are read
// after its own row.
// One query is in flight at a time; o_in_stall is high until its result has
// moved to the output register. Loads are taken while a result waits there.
// If the receiver stalls, the result holds and a following query waits at
// its end until the output register frees.
// Reset clears control state and sets node_count 16, rows_in_use 1024; table
// contents are undefined until loaded and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
`include "best_subset_score_search_unit_macros.svh"
module best_subset_score_search_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire bsss_pkg::t_in_beat                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output bsss_pkg::t_out_beat                    o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bsss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bsss_pkg::t_state                        r_state, n_state;
    logic [bsss_pkg::NCNT_W-1:0]             r_node_count;
    logic [bsss_pkg::CNT_W-1:0]              r_rows_in_use;
    logic                                    r_pend, n_pend;
    logic                                    r_ovalid, n_ovalid;
    logic [bsss_pkg::CNT_W-1:0]              r_addr, n_addr;
    logic [bsss_pkg::CNT_W-1:0]              r_end, n_end;
    logic [bsss_pkg::IDX_W-1:0]              r_pidx, n_pidx;
    logic [bsss_pkg::IDX_W-1:0]              r_ridx, n_ridx;
    logic                                    r_kind2, n_kind2;
    logic [bsss_pkg::NODE_W-1:0]             r_node, n_node;
    logic [bsss_pkg::MASK_W-1:0]             r_mask, n_mask;
    logic                                    r_found, n_found;
    logic signed [bsss_pkg::SCORE_W-1:0]     r_best, n_best;
    logic [bsss_pkg::IDX_W-1:0]              r_bidx, n_bidx;
    bsss_pkg::t_out_beat                     r_out, n_out;

    logic                                    accept;
    logic                                    ridx_ok;
    logic                                    range_empty;
    logic [bsss_pkg::IDX_W-1:0]              last_sat;
    logic [bsss_pkg::CNT_W-1:0]              lim;
    logic                                    scan_issue;
    logic                                    out_free;
    logic                                    take;
    logic [bsss_pkg::MASK_W-1:0]             cmp;
    logic                                    ram_we;
    logic [bsss_pkg::IDX_W-1:0]              ram_raddr;
    bsss_pkg::t_row                          ram_wrow;
    bsss_pkg::t_row                          rd_row;
    logic [bsss_pkg::ROW_W-1:0]              ram_rdata;

    assign o_in_stall  = (r_state != bsss_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovalid || !i_out_stall;

    assign ridx_ok     = ({1'b0, i_in_data.row_index} < bsss_pkg::ROWS_TOTAL);
    assign last_sat    = (i_in_data.range_last > bsss_pkg::LAST_ROW) ?
                         bsss_pkg::LAST_ROW : i_in_data.range_last;
    assign range_empty = (i_in_data.range_first > last_sat);
    assign lim         = (r_rows_in_use > bsss_pkg::ROWS_TOTAL) ?
                         bsss_pkg::ROWS_TOTAL : r_rows_in_use;
    assign scan_issue  = (r_state == bsss_pkg::S_SCAN) && (r_addr < r_end);

    always_comb begin
        for (int b = 0; b < bsss_pkg::MASK_W; b++) begin
            cmp[b] = (b < bsss_pkg::MASK_BITS) && (int'(r_node_count) > b);
        end
    end

    // table RAM
    assign ram_we    = accept && (i_in_data.kind == bsss_pkg::KIND_LOAD) && ridx_ok;
    assign ram_wrow  = '{node: i_in_data.node, mask: i_in_data.parent_mask,
                         score: i_in_data.entry_score};
    assign ram_raddr = (r_state == bsss_pkg::S_IDLE) ? i_in_data.row_index
                                                     : r_addr[bsss_pkg::IDX_W-1:0];
    assign rd_row    = bsss_pkg::t_row'(ram_rdata);

    bsss_ram #(
        .WIDTH (bsss_pkg::ROW_W),
        .DEPTH (bsss_pkg::TABLE_ROWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_data.row_index),
        .i_wdata (ram_wrow),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign take = r_pend && (rd_row.node == r_node) &&
                  (((rd_row.mask & ~r_mask) & cmp) == '0) &&
                  (!r_found || (rd_row.score > r_best)) &&
                  !(r_kind2 && (r_pidx == r_ridx));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsss_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in_data.kind)
                        bsss_pkg::KIND_SUBSET: begin
                            n_state = range_empty ? bsss_pkg::S_DONE : bsss_pkg::S_SCAN;
                        end
                        bsss_pkg::KIND_ROW: begin
                            n_state = ridx_ok ? bsss_pkg::S_OWN : bsss_pkg::S_DONE;
                        end
                        default: begin
                            n_state = bsss_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            bsss_pkg::S_OWN: begin
                n_state = (lim == '0) ? bsss_pkg::S_DONE : bsss_pkg::S_SCAN;
            end
            bsss_pkg::S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = bsss_pkg::S_DONE;
                end
            end
            bsss_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bsss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsss_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pend   = 1'b0;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        n_addr   = r_addr;
        n_end    = r_end;
        n_pidx   = r_pidx;
        n_ridx   = r_ridx;
        n_kind2  = r_kind2;
        n_node   = r_node;
        n_mask   = r_mask;
        n_found  = r_found;
        n_best   = r_best;
        n_bidx   = r_bidx;
        case (r_state)
            bsss_pkg::S_IDLE: begin
                n_found = 1'b0;
                n_best  = bsss_pkg::SCORE_MIN;
                n_bidx  = '0;
                n_node  = i_in_data.node;
                n_mask  = i_in_data.parent_mask;
                n_ridx  = i_in_data.row_index;
                n_kind2 = (i_in_data.kind == bsss_pkg::KIND_ROW);
                n_addr  = {1'b0, i_in_data.range_first};
                n_end   = (i_in_data.kind == bsss_pkg::KIND_ROW) ? lim :
                          ({1'b0, last_sat} + bsss_pkg::CNT_W'(1));
            end
            bsss_pkg::S_OWN: begin
                n_node  = rd_row.node;
                n_mask  = rd_row.mask;
                n_best  = rd_row.score;
                n_bidx  = r_ridx;
                n_found = 1'b1;
                n_addr  = '0;
            end
            bsss_pkg::S_SCAN: begin
                n_pend = scan_issue;
                n_pidx = r_addr[bsss_pkg::IDX_W-1:0];
                if (scan_issue) begin
                    n_addr = r_addr + bsss_pkg::CNT_W'(1);
                end
                if (take) begin
                    n_found = 1'b1;
                    n_best  = rd_row.score;
                    n_bidx  = r_pidx;
                end
            end
            bsss_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{best_score: r_best, best_index: r_bidx, found: r_found};
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bsss_pkg::S_IDLE;
            r_pend        <= 1'b0;
            r_ovalid      <= 1'b0;
            r_node_count  <= bsss_pkg::NODE_COUNT_RST;
            r_rows_in_use <= bsss_pkg::ROWS_IN_USE_RST;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (bsss_pkg::t_cfg_reg'(i_cfg_index))
                    bsss_pkg::CFG_NODE_COUNT: begin
                        r_node_count <= i_cfg_data[bsss_pkg::NCNT_W-1:0];
                    end
                    bsss_pkg::CFG_ROWS_IN_USE: begin
                        r_rows_in_use <= i_cfg_data[bsss_pkg::CNT_W-1:0];
                    end
                    default: begin
                        r_node_count <= r_node_count;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_addr  <= n_addr;
        r_end   <= n_end;
        r_pidx  <= n_pidx;
        r_ridx  <= n_ridx;
        r_kind2 <= n_kind2;
        r_node  <= n_node;
        r_mask  <= n_mask;
        r_found <= n_found;
        r_best  <= n_best;
        r_bidx  <= n_bidx;
    end

    `BSSS_ASSERT_NOW(a_pend_in_range, (r_state == bsss_pkg::S_SCAN) && r_pend,
        bsss_pkg::CNT_W'(r_pidx) < r_end)
    `BSSS_ASSERT_NOW(a_row_query_found, (r_state == bsss_pkg::S_SCAN) && r_kind2,
        r_found)
    `BSSS_ASSERT_NEXT(a_done_hands_over, (r_state == bsss_pkg::S_DONE) && out_free,
        r_ovalid && (r_state == bsss_pkg::S_IDLE))

endmodule
`default_nettype wire
